// ===== rtl/mrab_pkg.sv =====
// Package for the masked RGBA alpha blend: widths, register indexes and the divide-by-255 helper.
`default_nettype none

package mrab_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned ProdW    = 2 * ChanW;
  localparam int unsigned AlphaIdx = 3;

  localparam logic [ChanW-1:0] FullLevel = 8'd255;
  localparam logic [ChanW-1:0] WeightRst = 8'd128;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SOURCE_WEIGHT = 1'b0,
    CFG_OVERLAY_MODE  = 1'b1
  } cfg_idx_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;
  typedef logic [NumChan-1:0][ProdW-1:0] prod_vec_t;

  // Divide by 255: (x + 1 + (x >> 8)) >> 8, low 8 bits kept.
  // Exact floor(x / 255) for every x up to 255 * 255.
  function automatic chan_t div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] sum;
    sum = {1'b0, x} + (ProdW+1)'(1) + (ProdW+1)'(x >> ChanW);
    return sum[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/masked_rgba_alpha_blend_top.sv =====
// Top level of the masked RGBA alpha blend: four-stage pixel pipeline with config registers.
`default_nettype none

// Blends one source RGBA pixel onto one destination RGBA pixel under an 8-bit
// mask and gives one RGBA pixel. The block takes one pixel per clock while
// it is not stalled; four pixels can be in flight, with the output register
// as the last stage. Stage one forms the mask or alpha weight product, stage
// two reduces it and forms the second alpha product of the overlay path,
// stage three picks the channel weights and runs eight 8x8 multipliers,
// stage four divides by 255 and sums. Backpressure stalls the pipe up to its
// first empty stage; in_ready_o falls only when every stage holds a pixel
// and the output is not taken. Write source_weight and overlay_mode only while
// no pixel is in flight.
module masked_rgba_alpha_blend_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  // pixel input
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire mrab_pkg::chan_t     src_red_i,
  input  wire mrab_pkg::chan_t     src_green_i,
  input  wire mrab_pkg::chan_t     src_blue_i,
  input  wire mrab_pkg::chan_t     src_alpha_i,
  input  wire mrab_pkg::chan_t     dst_red_i,
  input  wire mrab_pkg::chan_t     dst_green_i,
  input  wire mrab_pkg::chan_t     dst_blue_i,
  input  wire mrab_pkg::chan_t     dst_alpha_i,
  input  wire mrab_pkg::chan_t     mask_level_i,
  // pixel output
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mrab_pkg::chan_t          out_red_o,
  output mrab_pkg::chan_t          out_green_o,
  output mrab_pkg::chan_t          out_blue_o,
  output mrab_pkg::chan_t          out_alpha_o
);
  import mrab_pkg::*;

  // configuration registers
  chan_t weight_q;
  logic  overlay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= WeightRst;
      overlay_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE_WEIGHT: weight_q  <= cfg_data_i;
        CFG_OVERLAY_MODE:  overlay_q <= cfg_data_i[0];
        default:           weight_q  <= weight_q;
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: weight times mask, or times source alpha for overlay at full mask
  pixel_t           src_in, dst_in;
  chan_t            mul1_sel;
  logic             m_zero_in, m_full_in;

  pixel_t           src1_q, dst1_q;
  chan_t            w1_q;
  logic             ovl1_q, m_zero1_q, m_full1_q;
  logic [ProdW-1:0] prod1_q;

  assign src_in    = {src_alpha_i, src_blue_i, src_green_i, src_red_i};
  assign dst_in    = {dst_alpha_i, dst_blue_i, dst_green_i, dst_red_i};
  assign m_zero_in = (mask_level_i == '0);
  assign m_full_in = (mask_level_i == FullLevel);
  assign mul1_sel  = (overlay_q && m_full_in) ? src_alpha_i : mask_level_i;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      src1_q    <= src_in;
      dst1_q    <= dst_in;
      w1_q      <= weight_q;
      ovl1_q    <= overlay_q;
      m_zero1_q <= m_zero_in;
      m_full1_q <= m_full_in;
      prod1_q   <= weight_q * mul1_sel;
    end
  end

  // stage 2: reduce the first product, scale by source alpha where needed
  chan_t            ws1_d;
  logic             second_d;

  pixel_t           src2_q, dst2_q;
  chan_t            w2_q, ws1_q;
  logic             ovl2_q, m_zero2_q, m_full2_q, second_q;
  logic [ProdW-1:0] prod2_q;

  assign ws1_d    = div255(prod1_q);
  assign second_d = ovl1_q && !m_zero1_q && !m_full1_q
                    && (src1_q[AlphaIdx] != FullLevel);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      src2_q    <= src1_q;
      dst2_q    <= dst1_q;
      w2_q      <= w1_q;
      ovl2_q    <= ovl1_q;
      m_zero2_q <= m_zero1_q;
      m_full2_q <= m_full1_q;
      ws1_q     <= ws1_d;
      second_q  <= second_d;
      prod2_q   <= ws1_d * src1_q[AlphaIdx];
    end
  end

  // stage 3: pick source and destination weights, multiply every channel
  chan_t     ws_c, wa_c, wb_c;
  logic      exact_c;
  prod_vec_t ps_d, pd_d;

  prod_vec_t ps3_q, pd3_q;
  logic      exact3_q;

  assign ws_c = second_q ? div255(prod2_q) : ws1_q;

  always_comb begin
    if (!ovl2_q) begin
      exact_c = m_zero2_q || m_full2_q;
      wa_c    = m_zero2_q ? '0 : (m_full2_q ? w2_q : ws_c);
      wb_c    = FullLevel - w2_q;
    end else if (m_zero2_q) begin
      // pass the destination through
      exact_c = 1'b1;
      wa_c    = '0;
      wb_c    = FullLevel;
    end else if (m_full2_q && (src2_q[AlphaIdx] == FullLevel)) begin
      exact_c = 1'b1;
      wa_c    = w2_q;
      wb_c    = FullLevel - w2_q;
    end else begin
      exact_c = 1'b0;
      wa_c    = ws_c;
      wb_c    = FullLevel - ws_c;
    end
  end

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      ps_d[i] = wa_c * src2_q[i];
      pd_d[i] = wb_c * dst2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      ps3_q    <= ps_d;
      pd3_q    <= pd_d;
      exact3_q <= exact_c;
    end
  end

  // stage 4: divide by 255, exact over the sum or fast per term
  pixel_t res_d;
  pixel_t res_q;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      if (exact3_q) begin
        res_d[i] = div255(ps3_q[i] + pd3_q[i]);
      end else begin
        res_d[i] = div255(ps3_q[i]) + div255(pd3_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];
  assign out_alpha_o = res_q[3];

endmodule

`default_nettype wire
